// ===== rtl/ioirq_pkg.sv =====
// ----------------------------------------------------------------------------
// ioirq_pkg
// Shared types and constants of the I/O interrupt controller register unit.
// ----------------------------------------------------------------------------
package ioirq_pkg;

  localparam int NUM_ENTRIES_DEF = 24;
  localparam int PIN_COUNT       = 24;

  localparam logic [7:0] REG_ID    = 8'h00;
  localparam logic [7:0] REG_VER   = 8'h01;
  localparam logic [7:0] REG_ARB   = 8'h02;
  localparam logic [7:0] REG_TABLE = 8'h10;

  localparam logic [7:0] VERSION_RST = 8'd17;

  typedef enum logic [1:0] {
    FN_READ  = 2'd0,
    FN_WRITE = 2'd1,
    FN_PINS  = 2'd2,
    FN_EOI   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic [7:0] dest;
    logic       mask;
    logic       trig;
    logic       rirr;
    logic       pol;
    logic       dstm;
    logic [2:0] dmode;
    logic [7:0] vector;
  } entry_t;

  localparam entry_t ENTRY_RST = '{dest: 8'h00, mask: 1'b1, trig: 1'b0, rirr: 1'b0,
                                   pol: 1'b0, dstm: 1'b0, dmode: 3'd0, vector: 8'h00};

  typedef struct packed {
    logic [7:0] vector;
    logic [2:0] dmode;
    logic       dstm;
    logic [7:0] dest;
  } irq_msg_t;

  typedef struct packed {
    logic latch_item;
    logic rd_bus;
    logic rd_scan;
    logic exec;
    logic idx_clr;
    logic step;
    logic idx_inc;
    logic finish;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  out_free;
    logic  ev_block;
    logic  scan_last;
  } sts_t;

endpackage

// ===== rtl/ioirq_if.sv =====
// ----------------------------------------------------------------------------
// ioirq_in_if / ioirq_out_if
// Valid/ready channels carrying request and result transactions.
// ----------------------------------------------------------------------------
interface ioirq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic        window_sel;
  logic [31:0] write_data;
  logic [ioirq_pkg::PIN_COUNT-1:0] pin_levels;
  logic [7:0]  eoi_vector;

  modport source (output valid, func, window_sel, write_data, pin_levels, eoi_vector,
                  input ready);
  modport sink   (input valid, func, window_sel, write_data, pin_levels, eoi_vector,
                  output ready);
endinterface

interface ioirq_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq_valid;
  logic [7:0]  irq_vector;
  logic [2:0]  irq_delivery_mode;
  logic        irq_dest_mode;
  logic [7:0]  irq_destination;
  logic        last;

  modport source (output valid, read_data, irq_valid, irq_vector, irq_delivery_mode,
                  irq_dest_mode, irq_destination, last, input ready);
  modport sink   (input valid, read_data, irq_valid, irq_vector, irq_delivery_mode,
                  irq_dest_mode, irq_destination, last, output ready);
endinterface

// ===== rtl/ioirq_ctrl.sv =====
// ----------------------------------------------------------------------------
// ioirq_ctrl
// Sequencer: bus access, entry scan for pin and EOI transactions, final result.
// ----------------------------------------------------------------------------
module ioirq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ioirq_pkg::sts_t   sts,
  output ioirq_pkg::cmd_t   cmd
);

  ioirq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ioirq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ioirq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_item = 1'b1;
          state_nxt      = ioirq_pkg::ST_FETCH;
        end
      end
      ioirq_pkg::ST_FETCH: begin
        cmd.rd_bus = 1'b1;
        state_nxt  = ioirq_pkg::ST_EXEC;
      end
      ioirq_pkg::ST_EXEC: begin
        if (sts.func == ioirq_pkg::FN_READ || sts.func == ioirq_pkg::FN_WRITE) begin
          if (sts.out_free) begin
            cmd.exec  = 1'b1;
            state_nxt = ioirq_pkg::ST_IDLE;
          end
        end else begin
          cmd.idx_clr = 1'b1;
          state_nxt   = ioirq_pkg::ST_SCAN_RD;
        end
      end
      ioirq_pkg::ST_SCAN_RD: begin
        cmd.rd_scan = 1'b1;
        state_nxt   = ioirq_pkg::ST_SCAN_EV;
      end
      ioirq_pkg::ST_SCAN_EV: begin
        if (!sts.ev_block) begin
          cmd.step = 1'b1;
          if (sts.scan_last) begin
            state_nxt = ioirq_pkg::ST_FINAL;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = ioirq_pkg::ST_SCAN_RD;
          end
        end
      end
      ioirq_pkg::ST_FINAL: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ioirq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ioirq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/ioirq_dpath.sv =====
// ----------------------------------------------------------------------------
// ioirq_dpath
// Registers, redirection table memory, entry evaluation and result register.
// ----------------------------------------------------------------------------
module ioirq_dpath #(
  parameter int NUM_ENTRIES = ioirq_pkg::NUM_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [7:0]                      cfg_wdata,
  input  logic [1:0]                      in_func,
  input  logic                            in_window_sel,
  input  logic [31:0]                     in_write_data,
  input  logic [ioirq_pkg::PIN_COUNT-1:0] in_pin_levels,
  input  logic [7:0]                      in_eoi_vector,
  input  ioirq_pkg::cmd_t                 cmd,
  output ioirq_pkg::sts_t                 sts,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [31:0]                     out_read_data,
  output logic                            out_irq_valid,
  output logic [7:0]                      out_irq_vector,
  output logic [2:0]                      out_irq_delivery_mode,
  output logic                            out_irq_dest_mode,
  output logic [7:0]                      out_irq_destination,
  output logic                            out_last
);

  localparam int IDX_W    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int SCAN_CNT = (NUM_ENTRIES < ioirq_pkg::PIN_COUNT) ? NUM_ENTRIES
                                                                 : ioirq_pkg::PIN_COUNT;
  localparam logic [8:0] TBL_END  = 9'(32'(ioirq_pkg::REG_TABLE) + 2 * NUM_ENTRIES);
  localparam logic [7:0] MAX_IDX  = 8'(NUM_ENTRIES - 1);
  localparam logic [IDX_W-1:0] LAST_ALL  = IDX_W'(NUM_ENTRIES - 1);
  localparam logic [IDX_W-1:0] LAST_PINS = IDX_W'(SCAN_CNT - 1);

  // configuration and bus-visible registers
  logic [7:0] version_r;
  logic [7:0] sel_r;
  logic [3:0] apic_id_r;
  logic [3:0] arb_id_r;
  logic [ioirq_pkg::PIN_COUNT-1:0] prev_pins_r;

  // latched transaction
  ioirq_pkg::func_t func_r;
  logic             wsel_r;
  logic [31:0]      wdata_r;
  logic [ioirq_pkg::PIN_COUNT-1:0] pins_r;
  logic [7:0]       eoiv_r;

  // table memory
  ioirq_pkg::entry_t mem [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] vld_r;
  ioirq_pkg::entry_t rd_data_r;
  logic              rd_vld_r;
  ioirq_pkg::entry_t entry_q;

  logic [IDX_W-1:0] idx_r;
  ioirq_pkg::irq_msg_t pend_r;
  logic                pend_v_r;

  logic        out_valid_r;
  logic [31:0] out_rdata_r;
  logic        out_irqv_r;
  ioirq_pkg::irq_msg_t out_msg_r;
  logic        out_last_r;

  logic [7:0]       sel_off;
  logic             is_table;
  logic [IDX_W-1:0] bus_idx;
  logic [31:0]      bus_rdata;
  ioirq_pkg::entry_t bus_new;
  ioirq_pkg::entry_t scan_new;
  ioirq_pkg::irq_msg_t cur_msg;
  logic [ioirq_pkg::PIN_COUNT-1:0] pins_sh;
  logic [ioirq_pkg::PIN_COUNT-1:0] prev_sh;
  logic             lvl_now;
  logic             lvl_before;
  logic             fire;
  logic             out_free;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  ioirq_pkg::entry_t wr_data;
  logic             bus_wr_tbl;

  assign sel_off  = sel_r - ioirq_pkg::REG_TABLE;
  assign is_table = (sel_r >= ioirq_pkg::REG_TABLE) && ({1'b0, sel_r} < TBL_END);
  assign bus_idx  = sel_off[IDX_W:1];
  assign entry_q  = rd_vld_r ? rd_data_r : ioirq_pkg::ENTRY_RST;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    bus_rdata = 32'h0;
    if (!wsel_r) begin
      bus_rdata = {24'h0, sel_r};
    end else if (sel_r == ioirq_pkg::REG_ID) begin
      bus_rdata = {4'h0, apic_id_r, 24'h0};
    end else if (sel_r == ioirq_pkg::REG_VER) begin
      bus_rdata = {8'h00, MAX_IDX, 8'h00, version_r};
    end else if (sel_r == ioirq_pkg::REG_ARB) begin
      bus_rdata = {4'h0, arb_id_r, 24'h0};
    end else if (is_table) begin
      if (sel_r[0]) begin
        bus_rdata = {entry_q.dest, 24'h0};
      end else begin
        bus_rdata = {15'h0, entry_q.mask, entry_q.trig, entry_q.rirr, entry_q.pol, 1'b0,
                     entry_q.dstm, entry_q.dmode, entry_q.vector};
      end
    end
  end

  always_comb begin
    bus_new = entry_q;
    if (sel_r[0]) begin
      bus_new.dest = wdata_r[31:24];
    end else begin
      bus_new.mask   = wdata_r[16];
      bus_new.trig   = wdata_r[15];
      bus_new.rirr   = entry_q.rirr & wdata_r[15];
      bus_new.pol    = wdata_r[13];
      bus_new.dstm   = wdata_r[11];
      bus_new.dmode  = wdata_r[10:8];
      bus_new.vector = wdata_r[7:0];
    end
  end

  // entry evaluation during a scan
  assign pins_sh    = pins_r >> idx_r;
  assign prev_sh    = prev_pins_r >> idx_r;
  assign lvl_now    = pins_sh[0] ^ entry_q.pol;
  assign lvl_before = prev_sh[0] ^ entry_q.pol;
  assign cur_msg    = '{vector: entry_q.vector, dmode: entry_q.dmode,
                        dstm: entry_q.dstm, dest: entry_q.dest};

  always_comb begin
    fire     = 1'b0;
    scan_new = entry_q;
    if (func_r == ioirq_pkg::FN_PINS) begin
      if (!entry_q.mask) begin
        if (entry_q.trig) begin
          fire = lvl_now && !entry_q.rirr;
          if (fire) begin
            scan_new.rirr = 1'b1;
          end
        end else begin
          fire = lvl_now && !lvl_before;
        end
      end
    end else if (entry_q.trig && entry_q.vector == eoiv_r) begin
      scan_new.rirr = 1'b0;
    end
  end

  assign sts.func      = func_r;
  assign sts.out_free  = out_free;
  assign sts.ev_block  = fire && pend_v_r && !out_free;
  assign sts.scan_last = (func_r == ioirq_pkg::FN_PINS) ? (idx_r == LAST_PINS)
                                                        : (idx_r == LAST_ALL);

  // memory ports
  assign bus_wr_tbl = cmd.exec && func_r == ioirq_pkg::FN_WRITE && wsel_r && is_table;
  assign rd_en   = cmd.rd_bus || cmd.rd_scan;
  assign rd_addr = cmd.rd_scan ? idx_r : bus_idx;
  assign wr_en   = cmd.step || bus_wr_tbl;
  assign wr_addr = cmd.step ? idx_r : bus_idx;
  assign wr_data = cmd.step ? scan_new : bus_new;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
      version_r   <= ioirq_pkg::VERSION_RST;
      sel_r       <= 8'h00;
      apic_id_r   <= 4'h0;
      arb_id_r    <= 4'h0;
      prev_pins_r <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
      if (cfg_we) begin
        version_r <= cfg_wdata;
      end
      if (cmd.exec && func_r == ioirq_pkg::FN_WRITE) begin
        if (!wsel_r) begin
          sel_r <= wdata_r[7:0];
        end else if (sel_r == ioirq_pkg::REG_ID) begin
          apic_id_r <= wdata_r[27:24];
          arb_id_r  <= wdata_r[27:24];
        end
      end
      if (cmd.step && fire) begin
        pend_v_r <= 1'b1;
      end
      if (cmd.finish) begin
        pend_v_r <= 1'b0;
        if (func_r == ioirq_pkg::FN_PINS) begin
          prev_pins_r <= pins_r;
        end
      end
      if (cmd.exec || cmd.finish || (cmd.step && fire && pend_v_r)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      func_r  <= ioirq_pkg::func_t'(in_func);
      wsel_r  <= in_window_sel;
      wdata_r <= in_write_data;
      pins_r  <= in_pin_levels;
      eoiv_r  <= in_eoi_vector;
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.step && fire) begin
      pend_r <= cur_msg;
    end
    if (cmd.exec) begin
      out_rdata_r <= (func_r == ioirq_pkg::FN_READ) ? bus_rdata : 32'h0;
      out_irqv_r  <= 1'b0;
      out_msg_r   <= '0;
      out_last_r  <= 1'b1;
    end else if (cmd.finish) begin
      out_rdata_r <= 32'h0;
      out_irqv_r  <= pend_v_r;
      out_msg_r   <= pend_v_r ? pend_r : '0;
      out_last_r  <= 1'b1;
    end else if (cmd.step && fire && pend_v_r) begin
      out_rdata_r <= 32'h0;
      out_irqv_r  <= 1'b1;
      out_msg_r   <= pend_r;
      out_last_r  <= 1'b0;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_read_data         = out_rdata_r;
  assign out_irq_valid         = out_irqv_r;
  assign out_irq_vector        = out_msg_r.vector;
  assign out_irq_delivery_mode = out_msg_r.dmode;
  assign out_irq_dest_mode     = out_msg_r.dstm;
  assign out_irq_destination   = out_msg_r.dest;
  assign out_last              = out_last_r;

endmodule

// ===== rtl/io_interrupt_controller_regs_unit.sv =====
// ----------------------------------------------------------------------------
// io_interrupt_controller_regs_unit
// I/O interrupt controller: index/data register window, redirection table,
// pin edge/level delivery and EOI handling.
//
//   channel   dir   handshake     payload
//   in_ch     in    valid/ready   func, window_sel, write_data, pin_levels, eoi_vector
//   out_ch    out   valid/ready   read_data, irq fields, last
//   cfg       in    cfg_we        cfg_wdata (version byte)
//
// Bus read/write: each transaction passes through accept, table read and execute.
// Pin update scans min(NUM_ENTRIES,24) entries; EOI scans all NUM_ENTRIES,
// with one table read and one table write per entry.
// Synchronous reset; the table reads its reset value through per-entry valid
// bits, so no clearing pass. A stalled out_ch holds the scan when a second
// message is ready; the next transaction is taken while the last result waits.
// ----------------------------------------------------------------------------
module io_interrupt_controller_regs_unit #(
  parameter int NUM_ENTRIES = ioirq_pkg::NUM_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  ioirq_in_if.sink    in_ch,
  ioirq_out_if.source out_ch
);

  ioirq_pkg::cmd_t cmd;
  ioirq_pkg::sts_t sts;
  logic            in_ready;

  assign in_ch.ready = in_ready;

  ioirq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ioirq_dpath #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .in_func               (in_ch.func),
    .in_window_sel         (in_ch.window_sel),
    .in_write_data         (in_ch.write_data),
    .in_pin_levels         (in_ch.pin_levels),
    .in_eoi_vector         (in_ch.eoi_vector),
    .cmd                   (cmd),
    .sts                   (sts),
    .out_ready             (out_ch.ready),
    .out_valid             (out_ch.valid),
    .out_read_data         (out_ch.read_data),
    .out_irq_valid         (out_ch.irq_valid),
    .out_irq_vector        (out_ch.irq_vector),
    .out_irq_delivery_mode (out_ch.irq_delivery_mode),
    .out_irq_dest_mode     (out_ch.irq_dest_mode),
    .out_irq_destination   (out_ch.irq_destination),
    .out_last              (out_ch.last)
  );

endmodule

// ===== dv/io_interrupt_controller_regs_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// io_interrupt_controller_regs_unit_tb
// Drives bus reads and writes through the index register and data window,
// pin level updates and EOIs, with random idle and stall on both channels.
// A scoreboard predicts every result transaction (read data, interrupt
// messages in entry order, last flag) and compares them field by field.
// ----------------------------------------------------------------------------
module io_interrupt_controller_regs_unit_tb;

  localparam int ENTRIES     = ioirq_pkg::NUM_ENTRIES_DEF;
  localparam int RIRR_B      = 14;
  localparam int POL_B       = 13;
  localparam int TRIG_B      = 15;
  localparam int MASK_B      = 16;
  localparam logic [31:0] LOW_WMASK  = 32'h0001_AFFF;
  localparam logic [31:0] HIGH_WMASK = 32'hFF00_0000;
  localparam int QUIET       = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    ioirq_pkg::func_t func;
    logic        wsel;
    logic [31:0] wdata;
    logic [23:0] pins;
    logic [7:0]  eoiv;
  } request_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_valid;
    logic [7:0]  vector;
    logic [2:0]  dmode;
    logic        dstm;
    logic [7:0]  dest;
    logic        last;
  } irq_result_t;

  class irq_scoreboard;
    logic [7:0]  version;
    logic [7:0]  reg_select;
    logic [3:0]  apic_id;
    logic [3:0]  arb_id;
    logic [63:0] redir [ENTRIES];
    logic [23:0] prev_pins;
    irq_result_t expected[$];
    int          errors;

    function new();
      version    = ioirq_pkg::VERSION_RST;
      reg_select = '0;
      apic_id    = '0;
      arb_id     = '0;
      prev_pins  = '0;
      errors     = 0;
      for (int i = 0; i < ENTRIES; i++) redir[i] = 64'h1 << MASK_B;
    endfunction

    function void note_request(request_t r);
      irq_result_t res;
      irq_result_t batch[$];
      logic [63:0] e;
      logic [7:0]  n;
      logic        in_table;
      logic        now_a;
      logic        was_a;
      logic        fire;
      res      = '0;
      in_table = (reg_select >= ioirq_pkg::REG_TABLE) &&
                 (reg_select < ioirq_pkg::REG_TABLE + 2 * ENTRIES);
      n        = (reg_select - ioirq_pkg::REG_TABLE) >> 1;
      case (r.func)
        ioirq_pkg::FN_READ: begin
          if (!r.wsel) res.read_data = {24'h0, reg_select};
          else if (reg_select == ioirq_pkg::REG_ID) res.read_data = {4'h0, apic_id, 24'h0};
          else if (reg_select == ioirq_pkg::REG_VER)
            res.read_data = {8'h0, 8'(ENTRIES - 1), 8'h0, version};
          else if (reg_select == ioirq_pkg::REG_ARB) res.read_data = {4'h0, arb_id, 24'h0};
          else if (in_table)
            res.read_data = reg_select[0] ? redir[n][63:32] : redir[n][31:0];
          batch.push_back(res);
        end
        ioirq_pkg::FN_WRITE: begin
          if (!r.wsel) reg_select = r.wdata[7:0];
          else if (reg_select == ioirq_pkg::REG_ID) begin
            apic_id = r.wdata[27:24];
            arb_id  = r.wdata[27:24];
          end else if (in_table) begin
            e = redir[n];
            if (reg_select[0]) e[63:32] = r.wdata & HIGH_WMASK;
            else begin
              e[31:0] = (e[31:0] & (32'h1 << RIRR_B)) | (r.wdata & LOW_WMASK);
              if (!e[TRIG_B]) e[RIRR_B] = 1'b0;
            end
            redir[n] = e;
          end
        end
        ioirq_pkg::FN_EOI: begin
          for (int i = 0; i < ENTRIES; i++)
            if (redir[i][TRIG_B] && redir[i][7:0] == r.eoiv) redir[i][RIRR_B] = 1'b0;
        end
        default: begin
          for (int i = 0; i < ENTRIES && i < ioirq_pkg::PIN_COUNT; i++) begin
            e = redir[i];
            if (!e[MASK_B]) begin
              now_a = r.pins[i] ^ e[POL_B];
              was_a = prev_pins[i] ^ e[POL_B];
              fire  = 1'b0;
              if (e[TRIG_B]) begin
                if (now_a && !e[RIRR_B]) begin
                  fire = 1'b1;
                  redir[i][RIRR_B] = 1'b1;
                end
              end else fire = now_a && !was_a;
              if (fire) begin
                res           = '0;
                res.irq_valid = 1'b1;
                res.vector    = e[7:0];
                res.dmode     = e[10:8];
                res.dstm      = e[11];
                res.dest      = e[63:56];
                batch.push_back(res);
              end
            end
          end
          prev_pins = r.pins;
        end
      endcase
      if (batch.size() == 0) batch.push_back('0);
      foreach (batch[k]) begin
        res      = batch[k];
        res.last = (k == batch.size() - 1);
        expected.push_back(res);
      end
    endfunction

    function int field_differs(string name, logic [31:0] want, logic [31:0] got);
      if (want === got) return 0;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      return 1;
    endfunction

    function void check_result(irq_result_t act);
      irq_result_t want;
      if (expected.size() == 0) begin
        $display("%0t: result with none expected, actual %h", $time, act);
        errors++;
        return;
      end
      want = expected.pop_front();
      errors += field_differs("read_data", want.read_data, act.read_data);
      errors += field_differs("irq_valid", 32'(want.irq_valid), 32'(act.irq_valid));
      errors += field_differs("irq_vector", 32'(want.vector), 32'(act.vector));
      errors += field_differs("irq_delivery_mode", 32'(want.dmode), 32'(act.dmode));
      errors += field_differs("irq_dest_mode", 32'(want.dstm), 32'(act.dstm));
      errors += field_differs("irq_destination", 32'(want.dest), 32'(act.dest));
      errors += field_differs("last", 32'(want.last), 32'(act.last));
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  logic       calm;
  logic       hold_req;
  int         items;
  int         stall_cycles;

  irq_scoreboard sb;

  ioirq_in_if  in_ch ();
  ioirq_out_if out_ch ();

  io_interrupt_controller_regs_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic send_item(request_t r);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= r.func;
    in_ch.window_sel <= r.wsel;
    in_ch.write_data <= r.wdata;
    in_ch.pin_levels <= r.pins;
    in_ch.eoi_vector <= r.eoiv;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(r);
    items++;
  endtask

  task automatic do_read(logic wsel);
    request_t r;
    r       = '0;
    r.func  = ioirq_pkg::FN_READ;
    r.wsel  = wsel;
    r.wdata = $urandom;
    r.pins  = 24'($urandom);
    r.eoiv  = 8'($urandom);
    send_item(r);
  endtask

  task automatic do_write(logic wsel, logic [31:0] data);
    request_t r;
    r       = '0;
    r.func  = ioirq_pkg::FN_WRITE;
    r.wsel  = wsel;
    r.wdata = data;
    r.eoiv  = 8'($urandom);
    send_item(r);
  endtask

  task automatic drive_pins(logic [23:0] levels);
    request_t r;
    r       = '0;
    r.func  = ioirq_pkg::FN_PINS;
    r.wsel  = 1'($urandom);
    r.wdata = $urandom;
    r.pins  = levels;
    send_item(r);
  endtask

  task automatic send_eoi(logic [7:0] vec);
    request_t r;
    r       = '0;
    r.func  = ioirq_pkg::FN_EOI;
    r.wsel  = 1'($urandom);
    r.wdata = $urandom;
    r.pins  = 24'($urandom);
    r.eoiv  = vec;
    send_item(r);
  endtask

  task automatic select_reg(logic [7:0] idx);
    logic [31:0] w;
    w      = $urandom;
    w[7:0] = idx;
    do_write(1'b0, w);
  endtask

  function automatic logic [7:0] pick_reg();
    case ($urandom_range(0, 5))
      0:       return ioirq_pkg::REG_ID;
      1:       return ioirq_pkg::REG_VER;
      2:       return ioirq_pkg::REG_ARB;
      5:       return 8'($urandom);
      default: return ioirq_pkg::REG_TABLE + 8'($urandom_range(0, 2 * ENTRIES - 1));
    endcase
  endfunction

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (QUIET) @(posedge clk);
  endtask

  task automatic set_version(logic [7:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.version = v;
    cfg_we    <= 1'b0;
  endtask

  task automatic rand_op();
    logic [31:0] lo;
    logic [7:0]  n;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      n  = 8'($urandom_range(0, ENTRIES - 1));
      lo = $urandom;
      if ($urandom_range(0, 3) != 0) lo[MASK_B] = 1'b0;
      if ($urandom_range(0, 2) == 0) begin
        select_reg(8'(ioirq_pkg::REG_TABLE + 2 * n + 1));
        do_write(1'b1, $urandom);
      end
      select_reg(8'(ioirq_pkg::REG_TABLE + 2 * n));
      do_write(1'b1, lo);
    end else if (pick < 42) begin
      if ($urandom_range(0, 3) == 0) do_read(1'b0);
      else begin
        select_reg(pick_reg());
        do_read(1'b1);
      end
    end else if (pick < 50) begin
      select_reg(pick_reg());
      do_write(1'b1, $urandom);
    end else if (pick < 85) begin
      case ($urandom_range(0, 3))
        0:       drive_pins(24'($urandom));
        1:       drive_pins(sb.prev_pins);
        default: drive_pins(sb.prev_pins ^ 24'($urandom & $urandom));
      endcase
    end else begin
      if ($urandom_range(0, 3) == 0) send_eoi(8'($urandom));
      else send_eoi(sb.redir[$urandom_range(0, ENTRIES - 1)][7:0]);
    end
  endtask

  task automatic run_phase(int target);
    while (items < target) rand_op();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.read_data, out_ch.irq_valid, out_ch.irq_vector,
                        out_ch.irq_delivery_mode, out_ch.irq_dest_mode,
                        out_ch.irq_destination, out_ch.last});
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    sb           = new();
    items        = 0;
    stall_cycles = 0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= '0;
    in_ch.window_sel <= 1'b0;
    in_ch.write_data <= '0;
    in_ch.pin_levels <= '0;
    in_ch.eoi_vector <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register window corners at reset version
    do_read(1'b0);
    do_write(1'b1, 32'hFFFF_FFFF);
    do_read(1'b1);
    select_reg(ioirq_pkg::REG_VER);
    do_read(1'b1);
    do_write(1'b1, 32'hFFFF_FFFF);
    select_reg(ioirq_pkg::REG_ARB);
    do_write(1'b1, 32'h0000_0000);
    do_read(1'b1);
    select_reg(8'hFF);
    do_write(1'b1, 32'hFFFF_FFFF);
    do_read(1'b1);
    do_read(1'b0);
    drive_pins(24'hFF_FFFF);
    // entry 0: level, active low, then edge with reserved delivery mode
    select_reg(ioirq_pkg::REG_TABLE + 8'd1);
    do_write(1'b1, 32'hFFFF_FFFF);
    select_reg(ioirq_pkg::REG_TABLE);
    do_write(1'b1, 32'h0000_FFFF);
    do_read(1'b1);
    drive_pins(24'hFF_FFFE);
    drive_pins(24'hFF_FFFE);
    do_read(1'b1);
    send_eoi(8'hFF);
    do_write(1'b1, 32'h0000_0320);
    drive_pins(24'h00_0001);
    drive_pins(24'h00_0001);
    drive_pins(24'h00_0000);
    drive_pins(24'h00_0001);

    set_version(8'hFF);
    hold_req = 1'b1;
    run_phase(90);
    set_version(8'h00);
    run_phase(150);
    set_version(8'($urandom));
    calm = 1'b1;
    run_phase(210);

    wait_idle();
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
